// ===== hdl/oph_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oph_pkg
// Shared types and constants for the OpenPGP packet header parser: request
// payload structs, parser phase and status codes, register indexes.
// ----------------------------------------------------------------------------
package oph_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WANTED_TYPE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STOP_TYPE   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STOP_ENABLE = 2'd2;

    // Tag and length byte constants
    localparam logic [7:0] LEN_FIVE_BYTE   = 8'd255;
    localparam logic [7:0] LEN_PARTIAL_MIN = 8'd224;
    localparam logic [7:0] LEN_TWO_MIN     = 8'd192;
    localparam logic [1:0] OLD_KIND_ONE    = 2'd0;
    localparam logic [1:0] OLD_KIND_TWO    = 2'd1;
    localparam logic [1:0] OLD_KIND_FOUR   = 2'd2;
    localparam logic [1:0] OLD_KIND_INDET  = 2'd3;

    typedef enum logic [2:0] {
        PH_TAG,
        PH_NEWLEN,
        PH_NEW2,
        PH_MULTI,
        PH_BODY,
        PH_HALT
    } phase_t;

    typedef enum logic [3:0] {
        ST_HDR    = 4'd0,
        ST_FOUND  = 4'd1,
        ST_BODY   = 4'd2,
        ST_SKIP   = 4'd3,
        ST_STOP   = 4'd4,
        ST_ERR    = 4'd5,
        ST_TRUNC  = 4'd6,
        ST_END    = 4'd7,
        ST_HALTED = 4'd8
    } status_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } in_req_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  out_byte;
        logic [5:0]  packet_type;
        logic [31:0] packet_length;
        logic        body_last;
    } out_req_t;

endpackage

// ===== hdl/oph_parse_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oph_parse_core
// Parser state and one-step decode: tag, length bytes and body counting for
// each accepted byte, plus the configuration registers.
// ----------------------------------------------------------------------------
module oph_parse_core
    import oph_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      step,
    input  in_req_t                   in_data,
    output out_req_t                  result
);

    localparam logic [32:0] LEN_MAX = (33'd1 << LENGTH_BITS) - 33'd1;

    logic [5:0]             wanted_type_reg;
    logic [5:0]             stop_type_reg;
    logic                   stop_enable_reg;

    phase_t                 phase_reg, phase_next;
    logic [5:0]             cur_type_reg, cur_type_next;
    logic [31:0]            acc_reg, acc_next;
    logic [2:0]             left_reg, left_next;
    logic [LENGTH_BITS-1:0] body_rem_reg, body_rem_next;
    logic                   wanted_reg, wanted_next;

    logic [7:0]             b;
    logic [5:0]             tag_type;
    logic [31:0]            acc_shift;
    logic [2:0]             left_dec;
    logic [LENGTH_BITS-1:0] body_dec;
    logic [13:0]            two_byte_len;
    logic [31:0]            fin_raw;
    logic [31:0]            fin_len;
    logic                   fin_wanted;
    logic                   fin_empty;
    status_t                status;
    logic [7:0]             obyte;
    logic                   last;

    assign b            = in_data.in_byte;
    assign tag_type     = b[6] ? b[5:0] : {2'b00, b[5:2]};
    assign acc_shift    = {acc_reg[23:0], b};
    assign left_dec     = left_reg - 3'd1;
    assign body_dec     = body_rem_reg - LENGTH_BITS'(1);
    assign two_byte_len = {acc_reg[4:0], b} + 14'd192;

    // Select the length that completes the header in this phase, then saturate
    always_comb
    begin
        case (phase_reg)
            PH_NEWLEN: fin_raw = {24'd0, b};
            PH_NEW2:   fin_raw = {18'd0, two_byte_len};
            default:   fin_raw = acc_shift;
        endcase
    end

    assign fin_len    = ({1'b0, fin_raw} > LEN_MAX) ? LEN_MAX[31:0] : fin_raw;
    assign fin_wanted = (wanted_type_reg == 6'd0) || (cur_type_reg == wanted_type_reg);
    assign fin_empty  = (fin_len == 32'd0);

    // Advance the parser by one byte
    always_comb
    begin
        phase_next    = phase_reg;
        cur_type_next = cur_type_reg;
        acc_next      = acc_reg;
        left_next     = left_reg;
        body_rem_next = body_rem_reg;
        wanted_next   = wanted_reg;
        status        = ST_HDR;
        obyte         = 8'd0;
        last          = 1'b0;

        if (phase_reg == PH_HALT) begin
            status = ST_HALTED;
        end else if (in_data.stream_end) begin
            status     = (phase_reg == PH_TAG) ? ST_END : ST_TRUNC;
            phase_next = PH_HALT;
        end else begin
            case (phase_reg)
                PH_TAG:
                begin
                    if (!b[7]) begin
                        status     = ST_ERR;
                        phase_next = PH_HALT;
                    end else begin
                        cur_type_next = tag_type;
                        acc_next      = 32'd0;
                        if (stop_enable_reg && (tag_type == stop_type_reg)) begin
                            status     = ST_STOP;
                            phase_next = PH_HALT;
                        end else if (b[6]) begin
                            phase_next = PH_NEWLEN;
                        end else begin
                            case (b[1:0])
                                OLD_KIND_ONE:   left_next = 3'd1;
                                OLD_KIND_TWO:   left_next = 3'd2;
                                OLD_KIND_FOUR:  left_next = 3'd4;
                                default:        left_next = left_reg;
                            endcase
                            if (b[1:0] == OLD_KIND_INDET) begin
                                status     = ST_ERR;
                                phase_next = PH_HALT;
                            end else begin
                                phase_next = PH_MULTI;
                            end
                        end
                    end
                end
                PH_NEWLEN:
                begin
                    if (b == LEN_FIVE_BYTE) begin
                        left_next  = 3'd4;
                        phase_next = PH_MULTI;
                    end else if (b >= LEN_PARTIAL_MIN) begin
                        status     = ST_ERR;
                        phase_next = PH_HALT;
                    end else if (b >= LEN_TWO_MIN) begin
                        acc_next   = {24'd0, b};
                        left_next  = 3'd1;
                        phase_next = PH_NEW2;
                    end else begin
                        acc_next      = fin_len;
                        wanted_next   = fin_wanted;
                        body_rem_next = fin_len[LENGTH_BITS-1:0];
                        phase_next    = fin_empty ? PH_TAG : PH_BODY;
                        last          = fin_empty && fin_wanted;
                        status        = fin_wanted ? ST_FOUND : ST_SKIP;
                    end
                end
                PH_NEW2:
                begin
                    left_next     = 3'd0;
                    acc_next      = fin_len;
                    wanted_next   = fin_wanted;
                    body_rem_next = fin_len[LENGTH_BITS-1:0];
                    phase_next    = fin_empty ? PH_TAG : PH_BODY;
                    last          = fin_empty && fin_wanted;
                    status        = fin_wanted ? ST_FOUND : ST_SKIP;
                end
                PH_MULTI:
                begin
                    acc_next  = acc_shift;
                    left_next = left_dec;
                    if (left_dec == 3'd0) begin
                        acc_next      = fin_len;
                        wanted_next   = fin_wanted;
                        body_rem_next = fin_len[LENGTH_BITS-1:0];
                        phase_next    = fin_empty ? PH_TAG : PH_BODY;
                        last          = fin_empty && fin_wanted;
                        status        = fin_wanted ? ST_FOUND : ST_SKIP;
                    end
                end
                PH_BODY:
                begin
                    body_rem_next = body_dec;
                    if (wanted_reg) begin
                        status = ST_BODY;
                        obyte  = b;
                        last   = (body_dec == '0);
                    end else begin
                        status = ST_SKIP;
                    end
                    if (body_dec == '0) begin
                        phase_next = PH_TAG;
                    end
                end
                default:
                begin
                    status = ST_HALTED;
                end
            endcase
        end
    end

    // Report the updated type and length with each request
    always_comb
    begin
        result.status        = status;
        result.out_byte      = obyte;
        result.packet_type   = cur_type_next;
        result.packet_length = acc_next;
        result.body_last     = last;
    end

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wanted_type_reg <= 6'd0;
            stop_type_reg   <= 6'd0;
            stop_enable_reg <= 1'b0;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_WANTED_TYPE: wanted_type_reg <= cfg_data;
                CFG_STOP_TYPE:   stop_type_reg   <= cfg_data;
                CFG_STOP_ENABLE: stop_enable_reg <= cfg_data[0];
                default:         stop_enable_reg <= stop_enable_reg;
            endcase
        end
    end

    // Update parser state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg    <= PH_TAG;
            cur_type_reg <= 6'd0;
            acc_reg      <= 32'd0;
            left_reg     <= 3'd0;
            body_rem_reg <= '0;
            wanted_reg   <= 1'b0;
        end else if (step) begin
            phase_reg    <= phase_next;
            cur_type_reg <= cur_type_next;
            acc_reg      <= acc_next;
            left_reg     <= left_next;
            body_rem_reg <= body_rem_next;
            wanted_reg   <= wanted_next;
        end
    end

endmodule

// ===== hdl/oph_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oph_out_buf
// Result register with a skid stage: holds one request on the output and
// one more while the output is stalled.
// ----------------------------------------------------------------------------
module oph_out_buf
    import oph_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  out_req_t push_data,
    output logic     full,
    output logic     out_valid,
    input  logic     out_stall,
    output out_req_t out_data
);

    logic     main_valid_reg, main_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    out_req_t main_reg, main_next;
    out_req_t skid_reg, skid_next;
    logic     main_free;

    assign main_free = !main_valid_reg || !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // Refill the output from the skid stage first, else from the new request
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (main_free) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                main_next       = push_data;
                main_valid_next = push;
            end
        end else if (push) begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

// ===== hdl/openpgp_packet_header_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// openpgp_packet_header_parser
// Decodes OpenPGP packet tags and lengths from a byte stream, passes body
// bytes of wanted packets out and skips the rest; halts on an error, the stop type or stream end.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_stall   in_data   (in_req_t)
//   out      output     out_valid / out_stall out_data  (out_req_t)
//   cfg      input      cfg_write             cfg_index, cfg_data
//
// One byte per cycle while in_stall is low; each accepted byte gives one registered result.
// The combinational parser step feeds the result register.
// Reset clears all parser state and configuration to zero, phase to tag.
// A two-deep output buffer holds one extra result during a stall; in_stall rises only when
// both the result register and the skid stage are occupied.
// ----------------------------------------------------------------------------
module openpgp_packet_header_parser
    import oph_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  in_req_t                   in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output out_req_t                  out_data
);

    logic     step;
    logic     buf_full;
    out_req_t step_result;

    // Accept a request whenever the skid stage is free
    assign in_stall = buf_full;
    assign step     = in_valid && !buf_full;

    oph_parse_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .in_data   (in_data),
        .result    (step_result)
    );

    oph_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .push_data (step_result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
